### rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the frame decoder
// Frame geometry, check bytes, channel packing and the transfer structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    // frame geometry
    localparam int SFD_FRAME_LEN  = 25;
    localparam int SFD_STORE_LEN  = SFD_FRAME_LEN - 1;
    localparam int SFD_POS_W      = 5;
    localparam int SFD_STORE_W    = SFD_STORE_LEN * 8;

    // channel geometry
    localparam int SFD_NUM_CHAN   = 16;
    localparam int SFD_CHAN_W     = 11;
    localparam int SFD_IDX_W      = 4;

    // check bytes
    localparam logic [7:0] SFD_HEADER    = 8'h0F;
    localparam logic [7:0] SFD_FLAGS_OK  = 8'h00;
    localparam logic [7:0] SFD_FOOTER_OK = 8'h00;

    // position of the footer byte and of the last channel
    localparam logic [SFD_POS_W-1:0] SFD_FOOTER_POS = SFD_POS_W'(SFD_FRAME_LEN - 1);
    localparam logic [SFD_IDX_W-1:0] SFD_LAST_CHAN  = SFD_IDX_W'(SFD_NUM_CHAN - 1);

    // input transfer
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_gap;
    } sfd_in_t;

    // result transfer
    typedef struct packed {
        logic [SFD_IDX_W-1:0]  channel_index;
        logic [SFD_CHAN_W-1:0] channel_value;
        logic                  frame_valid;
        logic                  last;
    } sfd_out_t;

    typedef logic [SFD_NUM_CHAN-1:0][SFD_CHAN_W-1:0] sfd_chan_array_t;

    // completed frame handed from assembler to emitter
    typedef struct packed {
        logic            load;
        logic            frame_valid;
        sfd_chan_array_t chans;
    } sfd_frame_t;

endpackage : sfd_pkg

`default_nettype wire

### rtl/sfd_assembler.sv
// ----------------------------------------------------------------------------
// sfd_assembler: byte collection and frame check
// Registers each byte, tracks the byte position, keeps frame bytes 0..23
// and on the footer byte checks the frame and unpacks all channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_assembler (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    byte_valid,
    output logic                         byte_stall,
    input  wire sfd_pkg::sfd_in_t        byte_data,
    input  wire logic                    emit_busy,
    output sfd_pkg::sfd_frame_t          frame
);
    import sfd_pkg::*;

    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    sfd_in_t                hold_reg;
    logic [SFD_POS_W-1:0]   pos_reg;
    logic [SFD_POS_W-1:0]   pos_next;
    logic [7:0]             store_reg [SFD_STORE_LEN];
    logic [SFD_POS_W-1:0]   pos_eff;
    logic                   footer;
    logic                   advance;
    logic                   accept;
    logic [SFD_STORE_W-1:0] store_flat;
    logic                   check_ok;

    // position of the held byte; a gap restarts the frame
    assign pos_eff = hold_reg.frame_gap ? '0 : pos_reg;
    assign footer  = hold_valid_reg && (pos_eff >= SFD_FOOTER_POS);

    // a footer waits while the previous frame is still draining
    assign advance    = hold_valid_reg && !(footer && emit_busy);
    assign byte_stall = hold_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    // input register control
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // byte position
    always_comb
    begin
        pos_next = pos_reg;
        if (advance)
        begin
            pos_next = footer ? '0 : pos_eff + SFD_POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            pos_reg        <= pos_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= byte_data;
        end
    end

    // frame store, bytes 0..23
    always_ff @(posedge clk)
    begin
        if (advance && !footer)
        begin
            store_reg[pos_eff] <= hold_reg.rx_byte;
        end
    end

    // flat little-endian view of the stored bytes
    always_comb
    begin
        for (int i = 0; i < SFD_STORE_LEN; i++)
        begin
            store_flat[i*8 +: 8] = store_reg[i];
        end
    end

    // header, flags and footer check
    assign check_ok = (store_reg[0] == SFD_HEADER) &&
                      (store_reg[SFD_STORE_LEN-1] == SFD_FLAGS_OK) &&
                      (hold_reg.rx_byte == SFD_FOOTER_OK);

    assign frame.load        = advance && footer;
    assign frame.frame_valid = check_ok;

    // channel unpack, 11 bits each starting after the header byte
    for (genvar k = 0; k < SFD_NUM_CHAN; k++)
    begin : g_chan
        assign frame.chans[k] = check_ok ? store_flat[8 + SFD_CHAN_W*k +: SFD_CHAN_W] : '0;
    end

endmodule : sfd_assembler

`default_nettype wire

### rtl/sfd_emitter.sv
// ----------------------------------------------------------------------------
// sfd_emitter: channel result sequencer
// Holds the unpacked channels of one frame and sends them one per transfer
// through an output register, channel 0 first.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_emitter (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sfd_pkg::sfd_frame_t     frame,
    output logic                         emit_busy,
    output logic                         chan_valid,
    input  wire logic                    chan_stall,
    output sfd_pkg::sfd_out_t            chan_data
);
    import sfd_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [SFD_IDX_W-1:0] cnt_reg;
    logic [SFD_IDX_W-1:0] cnt_next;
    sfd_chan_array_t      chans_reg;
    logic                 valid_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    sfd_out_t             out_reg;
    logic                 push;
    logic                 at_last;

    assign at_last = (cnt_reg == SFD_LAST_CHAN);

    // move the next channel into the output register when it is free
    assign push = busy_reg && (!out_valid_reg || !chan_stall);

    // sequencer control
    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && chan_stall;
        if (frame.load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (push)
        begin
            cnt_next = cnt_reg + SFD_IDX_W'(1);
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (push)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // channel buffer
    always_ff @(posedge clk)
    begin
        if (frame.load)
        begin
            chans_reg <= frame.chans;
            valid_reg <= frame.frame_valid;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg.channel_index <= cnt_reg;
            out_reg.channel_value <= chans_reg[cnt_reg];
            out_reg.frame_valid   <= valid_reg;
            out_reg.last          <= at_last;
        end
    end

    assign emit_busy  = busy_reg;
    assign chan_valid = out_valid_reg;
    assign chan_data  = out_reg;

endmodule : sfd_emitter

`default_nettype wire

### rtl/sbus_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_top: 16-channel 11-bit serial frame decoder
// Collects 25-byte frames and emits one result per channel.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while the input does not stall. Bytes
// 0..23 of a frame are kept; on the 25th byte (the footer) the frame is
// checked (header 0x0F, flags and footer 0x00) and all 16 channels are
// unpacked into a channel buffer, which then sends 16 results, one per cycle
// while the result side does not stall, through an output register; the
// footer byte passes the input register before the frame is loaded.
// An invalid frame still gives 16 results, with value zero and frame_valid
// low. A byte with frame_gap set starts a new frame at byte 0. Since a frame
// is at least 25 bytes and the buffer sends 16 results, input never stalls
// unless the result side stalls long enough that a footer arrives while the
// channel buffer still holds the previous frame; that footer then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_decoder_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire sfd_pkg::sfd_in_t  byte_data,
    output logic                   chan_valid,
    input  wire logic              chan_stall,
    output sfd_pkg::sfd_out_t      chan_data
);
    import sfd_pkg::*;

    sfd_frame_t frame;
    logic       emit_busy;

    // byte collection and frame check
    sfd_assembler u_assembler (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .emit_busy  (emit_busy),
        .frame      (frame)
    );

    // channel result sequencing
    sfd_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .emit_busy  (emit_busy),
        .chan_valid (chan_valid),
        .chan_stall (chan_stall),
        .chan_data  (chan_data)
    );

`ifndef NO_ASSERTIONS
    // a frame is only loaded into an empty channel buffer
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frame.load |-> !emit_busy)
        else $error("frame loaded while channel buffer busy");

    // the buffer only becomes busy through a frame load
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(emit_busy) |-> $past(frame.load))
        else $error("channel buffer busy without a frame load");

    // input only stalls while a previous frame is draining
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> emit_busy)
        else $error("input stalled with idle channel buffer");
`endif

endmodule : sbus_frame_decoder_top

`default_nettype wire

### bench/tb_sbus_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_sbus_frame_decoder_top: self-checking bench for the serial frame decoder
// Sends received bytes as transfers. A behavioral predictor tracks the frame
// assembly and queues the 16 channel results that each footer should give.
// Every result transfer is checked in order against that queue. Both sides
// idle at random, with one stretch where neither side idles.
// ----------------------------------------------------------------------------
module tb_sbus_frame_decoder_top;

    import sfd_pkg::*;

    localparam int IDLE_PCT     = 18;
    localparam int WATCH_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 130;
    localparam int QUIET_BYTES  = 60;
    localparam int SETTLE_CYCLES = 40;

    typedef logic [7:0] frame_bytes_t [SFD_FRAME_LEN];
    typedef logic [SFD_CHAN_W-1:0] chan_set_t [SFD_NUM_CHAN];

    logic     clk;
    logic     rst_n;
    logic     byte_valid;
    logic     byte_stall;
    sfd_in_t  byte_data;
    logic     chan_valid;
    logic     chan_stall;
    sfd_out_t chan_data;

    // predicted frame assembly state
    logic [7:0]           rx_frame [SFD_STORE_LEN];
    logic [SFD_POS_W-1:0] rx_pos;

    // channel results still owed by the decoder, oldest first
    sfd_out_t pending_chans [$];
    sfd_out_t want;

    int errors;
    int bytes_sent;
    int idle_cycles = 0;
    bit quiet;

    sbus_frame_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .chan_valid (chan_valid),
        .chan_stall (chan_stall),
        .chan_data  (chan_data)
    );

    // clock
    always #5 clk = ~clk;

    // predict the decoder's response to one accepted byte
    task automatic decode_byte(input logic [7:0] rx, input logic gap);
        logic [SFD_POS_W-1:0]               pos;
        logic [SFD_NUM_CHAN*SFD_CHAN_W-1:0] payload;
        logic                               ok;
        sfd_out_t                           res;
        int                                 i;
        pos = gap ? '0 : rx_pos;
        if (pos < SFD_FOOTER_POS)
        begin
            rx_frame[pos] = rx;
            rx_pos = pos + 1'b1;
        end
        else
        begin
            // footer position: check bytes, then unpack bytes 1..22 lsb first
            ok = (rx_frame[0] == SFD_HEADER) &&
                 (rx_frame[SFD_STORE_LEN-1] == SFD_FLAGS_OK) &&
                 (rx == SFD_FOOTER_OK);
            for (i = 1; i < SFD_STORE_LEN - 1; i++)
                payload[8*(i-1) +: 8] = rx_frame[i];
            for (i = 0; i < SFD_NUM_CHAN; i++)
            begin
                res.channel_index = SFD_IDX_W'(i);
                res.channel_value = ok ? payload[SFD_CHAN_W*i +: SFD_CHAN_W] : '0;
                res.frame_valid   = ok;
                res.last          = (i == SFD_NUM_CHAN - 1);
                pending_chans.push_back(res);
            end
            rx_pos = '0;
        end
    endtask

    // pack 16 channels into a well-formed frame
    function automatic frame_bytes_t build_frame(input chan_set_t chans);
        frame_bytes_t                       f;
        logic [SFD_NUM_CHAN*SFD_CHAN_W-1:0] payload;
        int                                 i;
        for (i = 0; i < SFD_NUM_CHAN; i++)
            payload[SFD_CHAN_W*i +: SFD_CHAN_W] = chans[i];
        f[0] = SFD_HEADER;
        for (i = 1; i < SFD_STORE_LEN - 1; i++)
            f[i] = payload[8*(i-1) +: 8];
        f[SFD_STORE_LEN-1] = SFD_FLAGS_OK;
        f[SFD_FRAME_LEN-1] = SFD_FOOTER_OK;
        return f;
    endfunction

    // one byte transfer, with an optional random idle beforehand
    task automatic push_byte(input logic [7:0] rx, input logic gap);
        int pause;
        pause = 0;
        if (!quiet)
        begin
            while ($urandom_range(99) < IDLE_PCT)
                pause++;
        end
        if (pause > 0)
        begin
            byte_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= '{rx_byte: rx, frame_gap: gap};
        do
            @(posedge clk);
        while (byte_stall);
        decode_byte(rx, gap);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_bytes_t f, input logic gap0);
        int i;
        push_byte(f[0], gap0);
        for (i = 1; i < SFD_FRAME_LEN; i++)
            push_byte(f[i], 1'b0);
    endtask

    // hold off the sender until every owed result has come out
    task automatic drain_results;
        byte_valid <= 1'b0;
        wait (pending_chans.size() == 0);
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    // extreme and patterned channel values in valid frames
    task automatic test_valid_frames;
        chan_set_t c;
        int        k;
        for (k = 0; k < SFD_NUM_CHAN; k++)
            c[k] = '1;
        send_frame(build_frame(c), 1'b1);
        for (k = 0; k < SFD_NUM_CHAN; k++)
            c[k] = '0;
        send_frame(build_frame(c), 1'b0);
        for (k = 0; k < SFD_NUM_CHAN; k++)
            c[k] = k[0] ? 11'h2AA : 11'h555;
        send_frame(build_frame(c), 1'b0);
    endtask

    // bad header, bad flags and bad footer each void the frame
    task automatic test_bad_checks;
        chan_set_t    c;
        frame_bytes_t f;
        int           k;
        for (k = 0; k < SFD_NUM_CHAN; k++)
            c[k] = '1;
        f = build_frame(c);
        f[0] = 8'hF0;
        send_frame(f, 1'b0);
        f = build_frame(c);
        f[SFD_STORE_LEN-1] = 8'h08;
        send_frame(f, 1'b0);
        f = build_frame(c);
        f[SFD_FRAME_LEN-1] = 8'hFF;
        send_frame(f, 1'b0);
    endtask

    // gap mid-frame and gap on the footer position both restart the frame
    task automatic test_realign;
        chan_set_t    c;
        frame_bytes_t f;
        int           k;
        for (k = 0; k < SFD_NUM_CHAN; k++)
            c[k] = SFD_CHAN_W'(k * 131);
        f = build_frame(c);
        for (k = 0; k < 10; k++)
            push_byte(f[k], 1'b0);
        send_frame(f, 1'b1);
        for (k = 0; k < SFD_STORE_LEN; k++)
            push_byte(f[k], 1'b0);
        send_frame(f, 1'b1);
    endtask

    // mostly well-formed frames with random content, plus broken ones and noise
    task automatic test_random_traffic;
        chan_set_t    c;
        frame_bytes_t f;
        int           start;
        int           kind;
        int           n;
        int           k;
        bit           paused;
        start  = bytes_sent;
        paused = 0;
        quiet  = 1;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if (bytes_sent - start >= QUIET_BYTES)
                quiet = 0;
            if (!paused && bytes_sent - start >= RANDOM_BYTES / 2)
            begin
                drain_results();
                paused = 1;
            end
            for (k = 0; k < SFD_NUM_CHAN; k++)
                c[k] = $urandom_range(2047);
            f = build_frame(c);
            kind = $urandom_range(99);
            if (kind < 70)
                send_frame(f, (rx_pos != 0) || ($urandom_range(1) == 1));
            else if (kind < 80)
            begin
                // corrupt one check byte
                n = $urandom_range(2);
                k = (n == 0) ? 0 : (n == 1) ? SFD_STORE_LEN - 1 : SFD_FRAME_LEN - 1;
                f[k] = f[k] ^ 8'($urandom_range(1, 255));
                send_frame(f, (rx_pos != 0) || ($urandom_range(1) == 1));
            end
            else if (kind < 90)
            begin
                // truncated frame
                n = $urandom_range(1, SFD_STORE_LEN);
                for (k = 0; k < n; k++)
                    push_byte(f[k], (k == 0) && ($urandom_range(1) == 1));
            end
            else
            begin
                // line noise
                n = $urandom_range(1, 8);
                repeat (n) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    // result checking and receiver stall
    always @(posedge clk)
    begin
        if (rst_n && chan_valid && !chan_stall)
        begin
            if (pending_chans.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual index %0d value %0d",
                         $time, chan_data.channel_index, chan_data.channel_value);
            end
            else
            begin
                want = pending_chans.pop_front();
                check_field("channel_index", want.channel_index, chan_data.channel_index);
                check_field("channel_value", want.channel_value, chan_data.channel_value);
                check_field("frame_valid", want.frame_valid, chan_data.frame_valid);
                check_field("last", want.last, chan_data.last);
            end
        end
        chan_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (chan_valid && !chan_stall))
            idle_cycles <= 0;
        else if (idle_cycles == WATCH_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // test sequence
    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_data  = '0;
        chan_stall = 1'b0;
        quiet      = 0;
        rx_pos     = '0;
        errors     = 0;
        bytes_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_valid_frames();
        test_bad_checks();
        test_realign();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
